### rtl/core/stbs_pkg.sv
// Package for the sorted table binary search block.
// Holds the operation codes, stream field widths, controller states and the
// command and status structs shared by the controller and the datapath.
`default_nettype none

package stbs_pkg;

    // Operation codes carried in s_tuser.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Field widths of the stream items and of the configuration register.
    localparam int IDX_W      = 10;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 11;
    localparam int CFG_W      = 11;
    localparam int S_TDATA_W  = 80;
    localparam int M_FIELDS_W = 1 + 3 * IDX_W + COUNT_W;
    localparam int M_TDATA_W  = 48;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_FIRST,
        ST_EVAL_FIRST,
        ST_READ_LAST,
        ST_EVAL_LAST,
        ST_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_entry;
        logic start_search;
        logic init_bounds;
        logic read_probe;
        logic eval_probe;
        logic mode_last;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic active;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

### rtl/core/sorted_table_binary_search.sv
// Write items are taken only while idle. A search registers the key, runs the
// lowest-index search and then the highest-index search, each of at most
// ceil(log2(n + 1)) probes, and loads the result; a waiting result stalls the load.
// Each probe is a read state, which registers the table read, then an evaluate
// state that compares it. No new item is taken until the search result is loaded.
// Reset clears control state and the entry count; the table stays undefined.
`default_nettype none

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration: entries_in_use.
    input  wire logic                              cfg_wr_en,
    input  wire logic [stbs_pkg::CFG_W-1:0]        cfg_wr_data,
    // Input stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: write_index[9:0], write_value[41:10], search_key[73:42], zero pad.
    input  wire logic [stbs_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: operation[0].
    input  wire logic                              s_tuser,
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: found[0], hit_index[10:1], first_index[20:11],
    // last_index[30:21], occurrences[41:31], zero pad.
    output logic [stbs_pkg::M_TDATA_W-1:0]         m_tdata
);

    localparam int IW = stbs_pkg::IDX_W;
    localparam int VW = stbs_pkg::VALUE_W;

    stbs_pkg::cmd_t    cmd;
    stbs_pkg::status_t status;

    logic [IW-1:0]        write_index;
    logic signed [VW-1:0] write_value;
    logic signed [VW-1:0] search_key;

    // Unpack the input item.
    assign write_index = s_tdata[IW-1:0];
    assign write_value = s_tdata[IW+VW-1:IW];
    assign search_key  = s_tdata[IW+2*VW-1:IW+VW];

    stbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .write_index (write_index),
        .write_value (write_value),
        .search_key  (search_key),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

### rtl/core/stbs_ctrl.sv
// Controller of the sorted table binary search block.
// Sequences the lowest-index search and the highest-index search and the
// result hand-off; depends on stbs_pkg for states, commands and status.
`default_nettype none

module stbs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    input  wire logic             s_tuser,
    output logic                  s_tready,
    input  wire stbs_pkg::status_t status,
    output stbs_pkg::cmd_t        cmd
);

    stbs_pkg::state_t state_reg;
    stbs_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stbs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            stbs_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == stbs_pkg::OP_SEARCH)
                    begin
                        cmd.start_search = 1'b1;
                        state_next       = stbs_pkg::ST_READ_FIRST;
                    end
                    else
                    begin
                        cmd.write_entry = 1'b1;
                    end
                end
            end
            stbs_pkg::ST_READ_FIRST:
            begin
                if (status.active)
                begin
                    cmd.read_probe = 1'b1;
                    state_next     = stbs_pkg::ST_EVAL_FIRST;
                end
                else
                begin
                    cmd.init_bounds = 1'b1;
                    state_next      = stbs_pkg::ST_READ_LAST;
                end
            end
            stbs_pkg::ST_EVAL_FIRST:
            begin
                cmd.eval_probe = 1'b1;
                state_next     = stbs_pkg::ST_READ_FIRST;
            end
            stbs_pkg::ST_READ_LAST:
            begin
                cmd.mode_last = 1'b1;
                if (status.active)
                begin
                    cmd.read_probe = 1'b1;
                    state_next     = stbs_pkg::ST_EVAL_LAST;
                end
                else
                begin
                    state_next = stbs_pkg::ST_RESULT;
                end
            end
            stbs_pkg::ST_EVAL_LAST:
            begin
                cmd.mode_last  = 1'b1;
                cmd.eval_probe = 1'b1;
                state_next     = stbs_pkg::ST_READ_LAST;
            end
            stbs_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = stbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stbs_pkg::ST_IDLE;
            end
        endcase
    end

    // A probe is evaluated only in the cycle after its read was issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval_probe |-> $past(cmd.read_probe))
        else $error("probe evaluated without a preceding read");

    // A new item is never taken while a search is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.read_probe || cmd.eval_probe) |-> !s_tready)
        else $error("input ready during a search");

    // Each search result is loaded exactly once, right before going idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (state_reg == stbs_pkg::ST_IDLE))
        else $error("result loaded without returning to idle");

endmodule

`default_nettype wire

### rtl/core/stbs_datapath.sv
// Datapath of the sorted table binary search block.
// Holds the table memory, the entry count register, the search bounds, the
// probe compare, the result registers and the output register; uses stbs_pkg.
`default_nettype none

module stbs_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire stbs_pkg::cmd_t                    cmd,
    output stbs_pkg::status_t                      status,
    input  wire logic                              cfg_wr_en,
    input  wire logic [stbs_pkg::CFG_W-1:0]        cfg_wr_data,
    input  wire logic [stbs_pkg::IDX_W-1:0]        write_index,
    input  wire logic signed [stbs_pkg::VALUE_W-1:0] write_value,
    input  wire logic signed [stbs_pkg::VALUE_W-1:0] search_key,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic [stbs_pkg::M_TDATA_W-1:0]         m_tdata
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int CW1 = CW + 1;
    localparam int IW  = stbs_pkg::IDX_W;
    localparam int NW  = stbs_pkg::COUNT_W;
    localparam int VW  = stbs_pkg::VALUE_W;

    logic [stbs_pkg::CFG_W-1:0] entries_reg;
    logic signed [VW-1:0]       table_mem [TABLE_DEPTH];
    logic signed [VW-1:0]       key_reg;
    logic signed [VW-1:0]       rd_mid_reg;
    logic signed [VW-1:0]       rd_nb_reg;
    logic [CW-1:0]              lo_reg;
    logic [CW-1:0]              hi_ex_reg;
    logic [AW-1:0]              mid_reg;
    logic                       hit_ok_reg;
    logic                       first_ok_reg;
    logic                       last_ok_reg;
    logic [AW-1:0]              hit_idx_reg;
    logic [AW-1:0]              first_idx_reg;
    logic [AW-1:0]              last_idx_reg;
    logic                       m_tvalid_reg;
    logic [stbs_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [CW-1:0]  n_used;
    logic [CW:0]    mid_sum;
    logic [AW-1:0]  mid;
    logic [AW-1:0]  nb_addr;
    logic [CW:0]    mid_plus;
    logic [CW-1:0]  span;
    logic           wr_in_range;
    logic           key_lt;
    logic           key_gt;
    logic           nb_differs;
    logic           edge_first;
    logic           edge_last;
    logic [CW:0]    count_full;
    logic [NW-1:0]  occ;

    // Entry count register, saturated to the table depth for searching.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            entries_reg <= cfg_wr_data;
        end
    end

    assign n_used = (32'(entries_reg) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                          : CW'(entries_reg);

    // Probe address: middle of the half-open interval [lo, hi_ex).
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_ex_reg} - 1'b1;
    assign mid     = mid_sum[AW:1];
    assign nb_addr = cmd.mode_last ? AW'(mid + 1'b1) : AW'(mid - 1'b1);
    assign span    = hi_ex_reg - lo_reg;
    assign status.active   = (lo_reg < hi_ex_reg);
    assign status.out_free = !m_tvalid_reg || m_tready;

    // Table memory: one write port, two registered read ports.
    assign wr_in_range = (32'(write_index) < 32'(TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && wr_in_range)
        begin
            table_mem[AW'(write_index)] <= write_value;
        end
        if (cmd.read_probe)
        begin
            rd_mid_reg <= table_mem[mid];
            rd_nb_reg  <= table_mem[nb_addr];
            mid_reg    <= mid;
        end
    end

    // Probe compare against the key and the neighbor entry.
    assign key_gt     = (rd_mid_reg > key_reg);
    assign key_lt     = (rd_mid_reg < key_reg);
    assign nb_differs = (rd_nb_reg != rd_mid_reg);
    assign mid_plus   = CW1'(mid_reg) + 1'b1;
    assign edge_first = (mid_reg == '0) || nb_differs;
    assign edge_last  = (mid_plus == CW1'(n_used)) || nb_differs;

    // Search bounds and per-search results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg       <= '0;
            hi_ex_reg    <= '0;
            hit_ok_reg   <= 1'b0;
            first_ok_reg <= 1'b0;
            last_ok_reg  <= 1'b0;
        end
        else if (cmd.start_search || cmd.init_bounds)
        begin
            lo_reg    <= '0;
            hi_ex_reg <= n_used;
            if (cmd.start_search)
            begin
                hit_ok_reg   <= 1'b0;
                first_ok_reg <= 1'b0;
                last_ok_reg  <= 1'b0;
            end
        end
        else if (cmd.eval_probe)
        begin
            if (key_gt)
            begin
                hi_ex_reg <= CW'(mid_reg);
            end
            else if (key_lt)
            begin
                lo_reg <= CW'(mid_plus);
            end
            else if (!cmd.mode_last)
            begin
                // Lowest-index search; its first match is the plain search hit.
                if (!hit_ok_reg)
                begin
                    hit_ok_reg <= 1'b1;
                end
                if (edge_first)
                begin
                    first_ok_reg <= 1'b1;
                    lo_reg       <= hi_ex_reg;
                end
                else
                begin
                    hi_ex_reg <= CW'(mid_reg);
                end
            end
            else
            begin
                if (edge_last)
                begin
                    last_ok_reg <= 1'b1;
                    lo_reg      <= hi_ex_reg;
                end
                else
                begin
                    lo_reg <= CW'(mid_plus);
                end
            end
        end
    end

    // Search key and matched indices.
    always_ff @(posedge clk)
    begin
        if (cmd.start_search)
        begin
            key_reg <= search_key;
        end
        if (cmd.eval_probe && !key_gt && !key_lt)
        begin
            if (!cmd.mode_last)
            begin
                if (!hit_ok_reg)
                begin
                    hit_idx_reg <= mid_reg;
                end
                if (edge_first)
                begin
                    first_idx_reg <= mid_reg;
                end
            end
            else if (edge_last)
            begin
                last_idx_reg <= mid_reg;
            end
        end
    end

    // Occurrence count from the first and last indices.
    assign count_full = CW1'(last_idx_reg) - CW1'(first_idx_reg) + 1'b1;
    assign occ = (first_ok_reg && last_ok_reg && (last_idx_reg >= first_idx_reg))
                 ? NW'(count_full) : '0;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_tdata_reg <= {
                {stbs_pkg::M_PAD_W{1'b0}},
                occ,
                last_ok_reg  ? IW'(last_idx_reg)  : IW'(0),
                first_ok_reg ? IW'(first_idx_reg) : IW'(0),
                hit_ok_reg   ? IW'(hit_idx_reg)   : IW'(0),
                hit_ok_reg
            };
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The search interval never turns inside out.
    assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_ex_reg)
        else $error("search bounds crossed");

    // Every evaluated probe shrinks the interval.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval_probe |=> span < $past(span))
        else $error("probe made no progress");

    // A result is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
